// ===== sv/fixed_length_frame_receiver_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-length frame receiver
// Concurrent checks are compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FIXED_LENGTH_FRAME_RECEIVER_DEFINES_SVH
`define FIXED_LENGTH_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FLFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("flfr assertion failed");

// next-cycle implication
`define FLFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("flfr assertion failed");

`else

`define FLFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define FLFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/flfr_pkg.sv =====
// ----------------------------------------------------------------------------
// flfr_pkg
// Shared constants and types of the fixed-length frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package flfr_pkg;

	// store depth default
	localparam int FRAME_STORE_BYTES_DEF = 19;

	// input opcodes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// frame format codes
	localparam logic [1:0] FMT_LONG  = 2'd0;
	localparam logic [1:0] FMT_MID   = 2'd1;
	localparam logic [1:0] FMT_SHORT = 2'd2;

	// register indexes (paddr bit 2)
	localparam logic REG_FORMAT  = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	// register reset values
	localparam logic [1:0] FORMAT_RESET  = FMT_LONG;
	localparam logic [7:0] TIMEOUT_RESET = 8'd20;

	// framing bytes
	localparam logic [7:0] START_BYTE   = 8'hFD;
	localparam logic [7:0] END_BYTE     = 8'hFF;
	localparam logic [7:0] SECOND_LONG  = 8'h0D;
	localparam logic [7:0] SECOND_MID   = 8'h10;
	localparam logic [7:0] SECOND_SHORT = 8'h0A;

	// frame lengths
	localparam logic [4:0] LEN_LONG  = 5'd19;
	localparam logic [4:0] LEN_MID   = 5'd16;
	localparam logic [4:0] LEN_SHORT = 5'd10;

	// store positions read for the result
	localparam logic [4:0] IDX_START   = 5'd0;
	localparam logic [4:0] IDX_SECOND  = 5'd1;
	localparam logic [4:0] IDX_DATA1   = 5'd5;
	localparam logic [4:0] IDX_DATA2   = 5'd6;
	localparam logic [4:0] IDX_DATA3   = 5'd7;
	localparam logic [4:0] IDX_STN_HI  = 5'd17;
	localparam logic [4:0] IDX_STN_LO  = 5'd18;

	typedef struct packed {
		logic [1:0] frame_format;
		logic [7:0] timeout_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  command;
		logic [7:0]  data_first;
		logic [7:0]  data_second;
		logic [7:0]  data_third;
		logic [15:0] station_id;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/flfr_if.sv =====
// ----------------------------------------------------------------------------
// flfr_in_if / flfr_out_if
// Valid/ready channels for input items and frame results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface flfr_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;

	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface flfr_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  command;
	logic [7:0]  data_first;
	logic [7:0]  data_second;
	logic [7:0]  data_third;
	logic [15:0] station_id;

	modport source (output valid, output command, output data_first, output data_second,
		output data_third, output station_id, input ready);
	modport sink   (input valid, input command, input data_first, input data_second,
		input data_third, input station_id, output ready);
endinterface

`default_nettype wire

// ===== sv/fixed_length_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// fixed_length_frame_receiver
// Receiver for fixed-length serial frames with a tick-driven timeout.
//
// Usage:
//   items   : input channel; opcode 0 carries a received byte in rx_byte,
//             opcode 1 is a timer tick.
//   results : one transaction per accepted frame: command, three data bytes
//             and the station id from store bytes 17 and 18.
//   APB     : register 0 frame_format at 0x0, register 1 timeout_limit at 0x4.
//             Write only while the block is idle.
// Throughput: one input transaction per cycle while no result is held up at
//   the output, set by the single input stage feeding the frame logic.
// Result path: the transaction completing the frame is held in the input
//   register, and its result is loaded into the output register from there.
// Reset: clears frame state, tick counter and the whole frame store, and
//   loads the register reset values; no clearing pass is needed.
// Stall: while a result waits at the output, the block keeps accepting
//   items until another result would need the output register; the input
//   stage then holds and items.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fixed_length_frame_receiver_defines.svh"

module fixed_length_frame_receiver
	import flfr_pkg::*;
#(
	parameter int FRAME_STORE_BYTES = FRAME_STORE_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	flfr_in_if.sink          items,
	flfr_out_if.source       results,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	cfg_t       cfg;
	result_t    core_res;
	result_t    res_q;
	logic       core_has_res;
	logic       valid_s1;
	logic       opcode_s1;
	logic [7:0] rx_byte_s1;
	logic       out_valid_q;
	logic       out_free;
	logic       adv;
	logic       step;
	logic       in_ready;

	flfr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	flfr_core #(
		.FRAME_STORE_BYTES (FRAME_STORE_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.opcode     (opcode_s1),
		.rx_byte    (rx_byte_s1),
		.cfg        (cfg),
		.has_result (core_has_res),
		.result     (core_res)
	);

	// stage 1 moves on unless it makes a result and the output is occupied
	assign out_free = !out_valid_q || results.ready;
	assign adv      = !core_has_res || out_free;
	assign step     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;
	assign items.ready = in_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && items.valid) begin
			opcode_s1  <= items.opcode;
			rx_byte_s1 <= items.rx_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && core_has_res) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && core_has_res)
			res_q <= core_res;
	end

	assign results.valid       = out_valid_q;
	assign results.command     = res_q.command;
	assign results.data_first  = res_q.data_first;
	assign results.data_second = res_q.data_second;
	assign results.data_third  = res_q.data_third;
	assign results.station_id  = res_q.station_id;

	// checks
	`FLFR_ASSERT_IMPLY(a_res_from_byte, clk, arst_n, valid_s1 && core_has_res, opcode_s1 == OP_BYTE)
	`FLFR_ASSERT_IMPLY(a_hold_blocks_in, clk, arst_n, valid_s1 && !adv, !in_ready)
	`FLFR_ASSERT_NEXT(a_res_lands, clk, arst_n, step && core_has_res, out_valid_q)

endmodule

`default_nettype wire

// ===== sv/flfr_regs.sv =====
// ----------------------------------------------------------------------------
// flfr_regs
// APB-style configuration registers: frame format and timeout limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flfr_regs
	import flfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	logic [1:0] format_q;
	logic [7:0] timeout_q;
	logic       wr_en;

	// register select is paddr bit 2; byte-lane bits are not decoded
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q  <= FORMAT_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_FORMAT:  format_q  <= pwdata[1:0];
				REG_TIMEOUT: timeout_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (paddr[2])
			REG_FORMAT:  prdata = {30'd0, format_q};
			REG_TIMEOUT: prdata = {24'd0, timeout_q};
			default:     prdata = 32'd0;
		endcase
	end

	assign cfg.frame_format  = format_q;
	assign cfg.timeout_limit = timeout_q;

endmodule

`default_nettype wire

// ===== sv/flfr_core.sv =====
// ----------------------------------------------------------------------------
// flfr_core
// Frame state, tick counter and frame store; one item processed per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flfr_core
	import flfr_pkg::*;
#(
	parameter int FRAME_STORE_BYTES = FRAME_STORE_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic       opcode,
	input  wire logic [7:0] rx_byte,
	input  wire cfg_t       cfg,
	output logic            has_result,
	output result_t         result
);

	localparam int IDX_W = $clog2(FRAME_STORE_BYTES);

	logic       in_frame_q;
	logic [4:0] byte_count_q;
	logic [7:0] tick_count_q;
	logic [7:0] store_q [FRAME_STORE_BYTES];

	logic [7:0] second;
	logic [4:0] length;
	logic       check_end;

	logic       in_frame_d;
	logic [4:0] byte_count_d;
	logic [7:0] tick_count_d;
	logic       wr_en;
	logic [4:0] wr_idx;
	logic [7:0] tick_inc;
	logic [4:0] cnt_inc;
	logic       bad_second;
	logic       done;

	// format decode; the unused code behaves as the long format
	always_comb begin
		unique case (cfg.frame_format)
			FMT_MID: begin
				second = SECOND_MID;   length = LEN_MID;   check_end = 1'b1;
			end
			FMT_SHORT: begin
				second = SECOND_SHORT; length = LEN_SHORT; check_end = 1'b1;
			end
			default: begin
				second = SECOND_LONG;  length = LEN_LONG;  check_end = 1'b0;
			end
		endcase
	end

	assign tick_inc   = tick_count_q + 8'd1;
	assign cnt_inc    = byte_count_q + 5'd1;
	assign bad_second = (byte_count_q == IDX_SECOND) && (rx_byte != second);
	assign done       = (cnt_inc >= length);

	// next state
	always_comb begin
		in_frame_d   = in_frame_q;
		byte_count_d = byte_count_q;
		tick_count_d = tick_count_q;
		wr_en        = 1'b0;
		wr_idx       = byte_count_q;
		has_result   = 1'b0;
		if (opcode == OP_TICK) begin
			if (in_frame_q) begin
				tick_count_d = tick_inc;
				if (tick_inc > cfg.timeout_limit)
					in_frame_d = 1'b0;
			end else begin
				tick_count_d = 8'd0;
			end
		end else if (!in_frame_q) begin
			tick_count_d = 8'd0;
			byte_count_d = 5'd0;
			if (rx_byte == START_BYTE) begin
				wr_en        = 1'b1;
				wr_idx       = IDX_START;
				byte_count_d = 5'd1;
				in_frame_d   = 1'b1;
			end
		end else begin
			if (bad_second)
				in_frame_d = 1'b0;
			// short formats drop a wrong second byte; the long one still stores it
			if (!(bad_second && check_end)) begin
				wr_en        = 1'b1;
				byte_count_d = cnt_inc;
				if (done) begin
					byte_count_d = 5'd0;
					in_frame_d   = 1'b0;
					has_result   = !check_end || (rx_byte == END_BYTE);
				end
			end
		end
	end

	// result fields read the store as it stands after this item's write
	always_comb begin
		result.data_first  = (wr_en && wr_idx == IDX_DATA1) ? rx_byte
			: store_q[IDX_DATA1[IDX_W-1:0]];
		result.data_second = (wr_en && wr_idx == IDX_DATA2) ? rx_byte
			: store_q[IDX_DATA2[IDX_W-1:0]];
		result.data_third  = (wr_en && wr_idx == IDX_DATA3) ? rx_byte
			: store_q[IDX_DATA3[IDX_W-1:0]];
		result.command     = result.data_second;
		result.station_id[15:8] = (wr_en && wr_idx == IDX_STN_HI) ? rx_byte
			: store_q[IDX_STN_HI[IDX_W-1:0]];
		result.station_id[7:0]  = (wr_en && wr_idx == IDX_STN_LO) ? rx_byte
			: store_q[IDX_STN_LO[IDX_W-1:0]];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			byte_count_q <= 5'd0;
			tick_count_q <= 8'd0;
		end else if (step) begin
			in_frame_q   <= in_frame_d;
			byte_count_q <= byte_count_d;
			tick_count_q <= tick_count_d;
		end
	end

	// frame store, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_STORE_BYTES; i++)
				store_q[i] <= 8'd0;
		end else if (step && wr_en && (32'(wr_idx) < FRAME_STORE_BYTES)) begin
			store_q[wr_idx[IDX_W-1:0]] <= rx_byte;
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_fixed_length_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver testbench
// Feeds serial bytes and timer ticks through the item channel and programs
// frame_format and timeout_limit over APB while the receiver is quiet. An
// in-bench frame decoder predicts every accepted frame; the result monitor
// compares each result transaction field by field, in order.
// ----------------------------------------------------------------------------

module tb_fixed_length_frame_receiver;
	import flfr_pkg::*;

	localparam int RESET_CYCLES   = 6;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int STALL_LIMIT    = 4000;
	localparam int STORE_BYTES    = FRAME_STORE_BYTES_DEF;

	typedef struct packed {
		logic       opcode;
		logic [7:0] rx_byte;
	} rx_item_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	// channel drive, known from time zero
	logic        item_valid = 1'b0;
	logic        item_opcode = OP_BYTE;
	logic [7:0]  item_byte = 8'h00;
	logic        res_ready = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	wire  [31:0] prdata;
	wire         pready;

	flfr_in_if  in_ch ();
	flfr_out_if out_ch ();

	assign in_ch.valid   = item_valid;
	assign in_ch.opcode  = item_opcode;
	assign in_ch.rx_byte = item_byte;
	assign out_ch.ready  = res_ready;

	fixed_length_frame_receiver dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (in_ch),
		.results (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// bench state
	rx_item_t pending_rx_items[$];
	result_t  expected_frames[$];
	result_t  decoded_frame;
	result_t  mon_frame;
	int       error_cnt = 0;
	int       idle_pct = 34;
	int       holdoff_req = 0;
	int       holdoff_ack = 0;
	int       holdoff_left = 0;
	int       quiet_cycles = 0;

	// decoder copy of registers and frame state
	logic [1:0] cfg_format = FORMAT_RESET;
	logic [7:0] cfg_timeout = TIMEOUT_RESET;
	logic       rx_in_frame = 1'b0;
	logic [4:0] rx_count = 5'd0;
	logic [7:0] rx_ticks = 8'd0;
	logic [7:0] rx_store [STORE_BYTES] = '{default: 8'h00};

	// Frame decoder: advances the state by one item, returns 1 with the
	// frame result when a frame is accepted.
	function automatic bit predict_frame_result(input rx_item_t it, output result_t res);
		logic [7:0] second_b;
		logic [4:0] flen;
		bit         need_end;
		res = '0;
		if (it.opcode == OP_TICK) begin
			if (rx_in_frame) begin
				rx_ticks = rx_ticks + 8'd1;
				if (rx_ticks > cfg_timeout)
					rx_in_frame = 1'b0;
			end else begin
				rx_ticks = 8'd0;
			end
			return 1'b0;
		end
		// hunting for a start byte
		if (!rx_in_frame) begin
			rx_ticks = 8'd0;
			rx_count = 5'd0;
			if (it.rx_byte == START_BYTE) begin
				rx_store[IDX_START] = it.rx_byte;
				rx_count = 5'd1;
				rx_in_frame = 1'b1;
			end
			return 1'b0;
		end
		case (cfg_format)
			FMT_MID: begin
				second_b = SECOND_MID;
				flen = LEN_MID;
				need_end = 1'b1;
			end
			FMT_SHORT: begin
				second_b = SECOND_SHORT;
				flen = LEN_SHORT;
				need_end = 1'b1;
			end
			default: begin
				second_b = SECOND_LONG;
				flen = LEN_LONG;
				need_end = 1'b0;
			end
		endcase
		// bad second byte: long format still stores it, short ones drop it
		if (rx_count == IDX_SECOND && it.rx_byte != second_b) begin
			rx_in_frame = 1'b0;
			if (need_end)
				return 1'b0;
		end
		if (rx_count < STORE_BYTES)
			rx_store[rx_count] = it.rx_byte;
		rx_count = rx_count + 5'd1;
		if (rx_count >= flen) begin
			rx_count = 5'd0;
			rx_in_frame = 1'b0;
			if (!need_end || it.rx_byte == END_BYTE) begin
				res.command     = rx_store[IDX_DATA2];
				res.data_first  = rx_store[IDX_DATA1];
				res.data_second = rx_store[IDX_DATA2];
				res.data_third  = rx_store[IDX_DATA3];
				res.station_id  = {rx_store[IDX_STN_HI], rx_store[IDX_STN_LO]};
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
			error_cnt++;
		end
	endfunction

	// item driver: predicts on acceptance, holds valid until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && in_ch.ready) begin
				if (predict_frame_result(pending_rx_items[0], decoded_frame))
					expected_frames.push_back(decoded_frame);
				void'(pending_rx_items.pop_front());
			end
			if (!(item_valid && !in_ch.ready)) begin
				if (pending_rx_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
					item_valid  <= 1'b1;
					item_opcode <= pending_rx_items[0].opcode;
					item_byte   <= pending_rx_items[0].rx_byte;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure and requested hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			holdoff_left <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_frames.size() == 0) begin
					$error("result transaction with no frame outstanding: command 0x%0h",
						out_ch.command);
					error_cnt++;
				end else begin
					mon_frame = expected_frames.pop_front();
					check_field("command", 16'(mon_frame.command), 16'(out_ch.command));
					check_field("data_first", 16'(mon_frame.data_first),
						16'(out_ch.data_first));
					check_field("data_second", 16'(mon_frame.data_second),
						16'(out_ch.data_second));
					check_field("data_third", 16'(mon_frame.data_third),
						16'(out_ch.data_third));
					check_field("station_id", mon_frame.station_id, out_ch.station_id);
				end
			end
			if (holdoff_left > 0) begin
				holdoff_left <= holdoff_left - 1;
				res_ready <= 1'b0;
			end else if (holdoff_ack != holdoff_req) begin
				holdoff_ack <= holdoff_req;
				holdoff_left <= HOLDOFF_CYCLES;
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// watchdog on cycles with no transaction of any kind
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("fixed_length_frame_receiver: mismatch");
				$finish;
			end
		end
	end

	function automatic void push_byte(input logic [7:0] b);
		rx_item_t it;
		it.opcode = OP_BYTE;
		it.rx_byte = b;
		pending_rx_items.push_back(it);
	endfunction

	function automatic void push_tick();
		rx_item_t it;
		it.opcode = OP_TICK;
		it.rx_byte = 8'($urandom_range(255));
		pending_rx_items.push_back(it);
	endfunction

	// One frame in the current format. Flaws: bad second byte, bad end byte
	// (end-byte formats only), or a truncated frame, with timeout ticks when the limit is below 40.
	function automatic int push_frame(input bit well_formed);
		logic [7:0] second_b;
		logic [7:0] b;
		int         flen;
		int         flaw;
		int         cut;
		int         n;
		bit         need_end;
		n = 0;
		case (cfg_format)
			FMT_MID: begin
				second_b = SECOND_MID;
				flen = LEN_MID;
				need_end = 1'b1;
			end
			FMT_SHORT: begin
				second_b = SECOND_SHORT;
				flen = LEN_SHORT;
				need_end = 1'b1;
			end
			default: begin
				second_b = SECOND_LONG;
				flen = LEN_LONG;
				need_end = 1'b0;
			end
		endcase
		flaw = well_formed ? -1 : $urandom_range(2);
		cut = (flaw == 2) ? $urandom_range(flen - 1, 2) : flen;
		for (int i = 0; i < cut; i++) begin
			if (i == 0) begin
				b = START_BYTE;
			end else if (i == 1) begin
				b = second_b;
				if (flaw == 0) begin
					// a start byte in second place must not restart the frame
					if ($urandom_range(1))
						b = START_BYTE;
					else
						do b = 8'($urandom_range(255)); while (b == second_b);
				end
			end else if (i == flen - 1 && need_end) begin
				b = END_BYTE;
				if (flaw == 1)
					do b = 8'($urandom_range(255)); while (b == END_BYTE);
			end else begin
				b = 8'($urandom_range(255));
			end
			push_byte(b);
			n++;
			if (i > 0 && $urandom_range(99) < 3) begin
				push_tick();
				n++;
			end
		end
		if (flaw == 2 && cfg_timeout < 40) begin
			repeat (cfg_timeout + 1) push_tick();
			n += cfg_timeout + 1;
		end
		return n;
	endfunction

	// mostly good frames, some broken ones, noise and tick bursts
	task automatic gen_random(input int budget);
		int made;
		int kind;
		int burst;
		made = 0;
		while (made < budget) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				made += push_frame(1'b1);
			end else if (kind < 82) begin
				made += push_frame(1'b0);
			end else if (kind < 90) begin
				burst = $urandom_range(4, 1);
				repeat (burst) push_byte(8'($urandom_range(255)));
				made += burst;
			end else begin
				burst = (cfg_timeout < 30) ? cfg_timeout + 2 : 30;
				burst = $urandom_range(burst, 1);
				repeat (burst) push_tick();
				made += burst;
			end
		end
	endtask

	task automatic reg_write(input logic reg_idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_idx == REG_FORMAT)
			cfg_format = value[1:0];
		else
			cfg_timeout = value[7:0];
	endtask

	// all items taken, all results back, then the output latency
	task automatic wait_quiet();
		while (pending_rx_items.size() != 0 || expected_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [1:0] fmt, input logic [7:0] lim,
		input int budget, input int idle);
		wait_quiet();
		reg_write(REG_FORMAT, {30'd0, fmt});
		reg_write(REG_TIMEOUT, {24'd0, lim});
		idle_pct = idle;
		gen_random(budget);
	endtask

	// stimulus sequence
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: idle tick, idle non-start byte, start then start as
		// second byte, then one full long frame with extreme data bytes
		push_tick();
		push_byte(8'h00);
		push_byte(START_BYTE);
		push_byte(START_BYTE);
		push_byte(START_BYTE);
		push_byte(SECOND_LONG);
		for (int i = 2; i < LEN_LONG; i++) begin
			case (i)
				IDX_DATA1:  push_byte(8'h00);
				IDX_DATA2:  push_byte(8'hFF);
				IDX_DATA3:  push_byte(8'h80);
				IDX_STN_HI: push_byte(8'hFF);
				IDX_STN_LO: push_byte(8'h01);
				default:    push_byte(8'(i));
			endcase
		end

		run_phase(FMT_LONG, TIMEOUT_RESET, 180, 34);
		run_phase(FMT_MID, 8'd1, 180, 34);
		run_phase(FMT_SHORT, 8'd255, 160, 34);

		// tick count wraps at the top limit, so this frame survives
		push_byte(START_BYTE);
		push_byte(SECOND_SHORT);
		repeat (260) push_tick();
		repeat (LEN_SHORT - 3) push_byte(8'($urandom_range(255)));
		push_byte(END_BYTE);

		// long stretch without idling on either side
		run_phase(FMT_LONG, 8'd255, 200, 0);
		run_phase(FMT_SHORT, 8'd1, 160, 34);
		run_phase(FMT_MID, 8'($urandom_range(254, 2)), 180, 34);

		// receiver holds off while short frames keep coming
		run_phase(FMT_SHORT, TIMEOUT_RESET, 0, 0);
		holdoff_req = holdoff_req + 1;
		repeat (15) void'(push_frame(1'b1));

		run_phase(FMT_LONG, 8'd1, 170, 34);

		wait_quiet();
		if (error_cnt == 0 && expected_frames.size() == 0)
			$display("fixed_length_frame_receiver: match");
		else
			$display("fixed_length_frame_receiver: mismatch");
		$finish;
	end

endmodule
